### rtl/text_console_writer_unit_macros.svh
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCW_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCW_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    localparam int TCW_COLUMNS = 80;
    localparam int TCW_ROWS    = 25;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BLANK = 8'h20;

    localparam logic [7:0] DEFAULT_COLOR_RESET = 8'h07;

    localparam logic REG_DEFAULT_COLOR = 1'b0;
    localparam logic REG_MONO_MODE     = 1'b1;

    typedef struct packed {
        logic load;
        logic home;
        logic cr;
        logic lf;
        logic advance;
        logic glyph_char;
        logic glyph_attr;
        logic glyph_next;
        logic ptr_clear;
        logic copy_step;
        logic fill_step;
        logic result_load;
    } tcw_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       is_lf;
        logic       is_cr;
        logic       mono;
        logic       last_col;
        logic       last_row;
        logic       more;
        logic       copy_last;
        logic       fill_last;
        logic       out_free;
    } tcw_status_t;

endpackage

`default_nettype wire

### rtl/text_console_writer_unit.sv
// Text console writer: keeps a ROWS x COLUMNS screen store (two bytes per cell, character then
// attribute, or one byte per cell in mono mode) and a cursor, and returns one result beat with
// the cursor position for every input beat. Input is taken only while the engine is idle; the
// result register lets the next beat in while the previous result still waits. A tab is four
// blank characters. Scrolling copies the store up one row and then fills the last row, and
// clear fills every used byte; both move one byte a cycle through the single write port of
// the screen memory. The store is not cleared at reset; its contents are undefined until a clear.
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
    parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  color,
    input  wire logic [11:0] read_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [6:0]       cursor_col,
    output logic [4:0]       cursor_row,
    output logic [10:0]      cursor_position,
    output logic [7:0]       read_data
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .char_code       (char_code),
        .color           (color),
        .read_address    (read_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_position (cursor_position),
        .read_data       (read_data)
    );

endmodule

`default_nettype wire

### rtl/tcw_dp.sv
`default_nettype none
`include "text_console_writer_unit_macros.svh"

module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tcw_pkg::tcw_cmd_t  cmd,
    output tcw_pkg::tcw_status_t    status,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic [1:0]         opcode,
    input  wire logic [7:0]         char_code,
    input  wire logic [7:0]         color,
    input  wire logic [11:0]        read_address,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [6:0]              cursor_col,
    output logic [4:0]              cursor_row,
    output logic [10:0]             cursor_position,
    output logic [7:0]              read_data
);
    import tcw_pkg::*;

    localparam int CELLS       = ROWS * COLUMNS;
    localparam int STORE_BYTES = 2 * CELLS;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int XW          = $clog2(COLUMNS);
    localparam int YW          = $clog2(ROWS);

    localparam logic [AW-1:0] FILL_LAST_MONO  = AW'(CELLS - 1);
    localparam logic [AW-1:0] FILL_LAST_COLOR = AW'(STORE_BYTES - 1);
    localparam logic [AW-1:0] COPY_LAST_MONO  = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] COPY_LAST_COLOR = AW'(STORE_BYTES - 2 * COLUMNS - 1);
    localparam logic [AW-1:0] OFS_MONO        = AW'(COLUMNS);
    localparam logic [AW-1:0] OFS_COLOR       = AW'(2 * COLUMNS);
    localparam logic [XW-1:0] X_LAST          = XW'(COLUMNS - 1);
    localparam logic [YW-1:0] Y_LAST          = YW'(ROWS - 1);

    logic [7:0] mem [STORE_BYTES];

    // configuration
    logic [7:0]    default_color_reg, default_color_next;
    logic          mono_reg, mono_next;

    // cursor and sweep pointer
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    // held item
    logic [1:0]    op_reg;
    logic [7:0]    ch_reg;
    logic [7:0]    glyph_ch_reg;
    logic [7:0]    attr_reg;
    logic [AW-1:0] addr_reg;
    logic          addr_ok_reg;

    // memory pipeline
    logic [7:0]    rd_reg;
    logic          copy_wr_reg, copy_wr_next;
    logic [AW-1:0] copy_dst_reg;

    // result
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    cursor_col_reg;
    logic [4:0]    cursor_row_reg;
    logic [10:0]   cursor_position_reg;
    logic [7:0]    read_data_reg;

    logic [AW-1:0] cell_idx;
    logic [AW-1:0] glyph_base;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [7:0]    fill_data;
    logic          last_col;
    logic          last_row;
    logic [31:0]   ra_ext;
    logic [31:0]   x_ext;
    logic [31:0]   y_ext;
    logic [31:0]   pos_ext;

    assign ra_ext  = 32'(read_address);
    assign x_ext   = 32'(x_reg);
    assign y_ext   = 32'(y_reg);
    assign pos_ext = 32'(cell_idx);

    assign last_col   = (x_reg == X_LAST);
    assign last_row   = (y_reg == Y_LAST);
    assign cell_idx   = AW'(y_reg) * AW'(COLUMNS) + AW'(x_reg);
    assign glyph_base = mono_reg ? cell_idx : {cell_idx[AW-2:0], 1'b0};
    assign fill_data  = (!mono_reg && ptr_reg[0]) ? default_color_reg : CH_BLANK;
    assign rd_addr    = cmd.copy_step ? ptr_reg + (mono_reg ? OFS_MONO : OFS_COLOR)
                                      : addr_reg;

    always_comb
    begin
        status.op        = op_reg;
        status.is_lf     = (ch_reg == CH_LF);
        status.is_cr     = (ch_reg == CH_CR);
        status.mono      = mono_reg;
        status.last_col  = last_col;
        status.last_row  = last_row;
        status.more      = (cnt_reg != 2'd0);
        status.copy_last = (ptr_reg == (mono_reg ? COPY_LAST_MONO : COPY_LAST_COLOR));
        status.fill_last = (ptr_reg == (mono_reg ? FILL_LAST_MONO : FILL_LAST_COLOR));
        status.out_free  = !out_valid_reg || !out_stall;
    end

    // one write port: pending copy beat, fill, or glyph bytes
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = ptr_reg;
        mem_wd = fill_data;
        if (copy_wr_reg)
        begin
            mem_we = 1'b1;
            mem_wa = copy_dst_reg;
            mem_wd = rd_reg;
        end
        else if (cmd.fill_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.glyph_char)
        begin
            mem_we = 1'b1;
            mem_wa = glyph_base;
            mem_wd = glyph_ch_reg;
        end
        else if (cmd.glyph_attr)
        begin
            mem_we = 1'b1;
            mem_wa = glyph_base + AW'(1);
            mem_wd = attr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        default_color_next = default_color_reg;
        mono_next          = mono_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEFAULT_COLOR: default_color_next = cfg_data;
                REG_MONO_MODE:     mono_next          = cfg_data[0];
                default:           mono_next          = mono_reg;
            endcase
        end
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (cmd.home)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (cmd.cr)
        begin
            x_next = '0;
        end
        else if (cmd.lf)
        begin
            if (!last_row)
            begin
                y_next = y_reg + YW'(1);
            end
        end
        else if (cmd.advance)
        begin
            if (last_col)
            begin
                x_next = '0;
                // on the last row the scroll keeps the cursor there
                if (!last_row)
                begin
                    y_next = y_reg + YW'(1);
                end
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_clear)
        begin
            ptr_next = '0;
        end
        else if (cmd.copy_step || cmd.fill_step)
        begin
            ptr_next = ptr_reg + AW'(1);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = (opcode == OP_PUT && char_code == CH_TAB) ? 2'd3 : 2'd0;
        end
        else if (cmd.glyph_next)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    assign copy_wr_next = cmd.copy_step;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= DEFAULT_COLOR_RESET;
            mono_reg          <= 1'b0;
            x_reg             <= '0;
            y_reg             <= '0;
            ptr_reg           <= '0;
            cnt_reg           <= 2'd0;
            copy_wr_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            default_color_reg <= default_color_next;
            mono_reg          <= mono_next;
            x_reg             <= x_next;
            y_reg             <= y_next;
            ptr_reg           <= ptr_next;
            cnt_reg           <= cnt_next;
            copy_wr_reg       <= copy_wr_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_dst_reg <= ptr_reg;
        if (cmd.load)
        begin
            op_reg       <= opcode;
            ch_reg       <= char_code;
            glyph_ch_reg <= (char_code == CH_TAB) ? CH_BLANK : char_code;
            attr_reg     <= color;
            addr_reg     <= ra_ext[AW-1:0];
            addr_ok_reg  <= (ra_ext < 32'(STORE_BYTES));
        end
        if (cmd.result_load)
        begin
            cursor_col_reg      <= x_ext[6:0];
            cursor_row_reg      <= y_ext[4:0];
            cursor_position_reg <= pos_ext[10:0];
            read_data_reg       <= (op_reg == OP_READ && addr_ok_reg) ? rd_reg : 8'h00;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_col      = cursor_col_reg;
    assign cursor_row      = cursor_row_reg;
    assign cursor_position = cursor_position_reg;
    assign read_data       = read_data_reg;

    `TCW_ASSERT_IMP(a_one_writer, 1'b1,
        $onehot0({copy_wr_reg, cmd.fill_step, cmd.glyph_char, cmd.glyph_attr}),
        "two sources drive the screen store write port")
    `TCW_ASSERT_IMP(a_cursor_range, 1'b1,
        (32'(x_reg) < 32'(COLUMNS)) && (32'(y_reg) < 32'(ROWS)),
        "cursor left the screen")
    `TCW_ASSERT_NXT(a_result_shown, cmd.result_load, out_valid_reg,
        "loaded result not presented")

endmodule

`default_nettype wire

### rtl/tcw_ctrl.sv
`default_nettype none
`include "text_console_writer_unit_macros.svh"

module tcw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t         cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_GLYPH    = 3'd2;
    localparam logic [2:0] S_ATTR     = 3'd3;
    localparam logic [2:0] S_COPY     = 3'd4;
    localparam logic [2:0] S_DRAIN    = 3'd5;
    localparam logic [2:0] S_FILL     = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] after_glyph;

    // where to go once a glyph has been stored and the cursor moved
    always_comb
    begin
        if (status.last_col && status.last_row)
        begin
            after_glyph = S_COPY;
        end
        else if (status.more)
        begin
            after_glyph = S_GLYPH;
        end
        else
        begin
            after_glyph = S_DONE;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.op)
                    OP_PUT:
                    begin
                        if (status.is_lf)
                        begin
                            if (status.last_row)
                            begin
                                cmd.ptr_clear = 1'b1;
                                state_next    = S_COPY;
                            end
                            else
                            begin
                                cmd.lf     = 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        else if (status.is_cr)
                        begin
                            cmd.cr     = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_GLYPH;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.home      = 1'b1;
                        cmd.ptr_clear = 1'b1;
                        state_next    = S_FILL;
                    end
                    // read data lands in the read register during this cycle
                    OP_READ:  state_next = S_DONE;
                    default:  state_next = S_DONE;
                endcase
            end
            S_GLYPH:
            begin
                cmd.glyph_char = 1'b1;
                if (status.mono)
                begin
                    cmd.advance    = 1'b1;
                    cmd.ptr_clear  = (after_glyph == S_COPY);
                    cmd.glyph_next = (after_glyph == S_GLYPH);
                    state_next     = after_glyph;
                end
                else
                begin
                    state_next = S_ATTR;
                end
            end
            S_ATTR:
            begin
                cmd.glyph_attr = 1'b1;
                cmd.advance    = 1'b1;
                cmd.ptr_clear  = (after_glyph == S_COPY);
                cmd.glyph_next = (after_glyph == S_GLYPH);
                state_next     = after_glyph;
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            // let the last copy beat reach the store
            S_DRAIN: state_next = S_FILL;
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    if (status.more)
                    begin
                        cmd.glyph_next = 1'b1;
                        state_next     = S_GLYPH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    `TCW_ASSERT_NXT(a_accept_dispatch, cmd.load, state_reg == S_DISPATCH,
        "accepted item not decoded next cycle")
    `TCW_ASSERT_NXT(a_copy_drain, state_reg == S_COPY && status.copy_last,
        state_reg == S_DRAIN, "scroll copy did not drain")
    `TCW_ASSERT_NXT(a_fill_done, state_reg == S_FILL && status.fill_last && !status.more,
        state_reg == S_DONE, "fill sweep did not finish the item")

endmodule

`default_nettype wire

### test/tb_text_console_writer_unit.sv
module tb_text_console_writer_unit;

    import tcw_pkg::*;

    localparam int COLS        = TCW_COLUMNS;
    localparam int LINES       = TCW_ROWS;
    localparam int CELLS       = COLS * LINES;
    localparam int STORE_BYTES = 2 * CELLS;
    localparam int QUIET_LIMIT = 20000;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] pos;
        logic [7:0]  data;
    } cursor_report_t;

    class console_scoreboard;
        logic [7:0]     screen [STORE_BYTES];
        bit             known [STORE_BYTES];
        int             col;
        int             row;
        logic [7:0]     fill_color;
        bit             mono;
        cursor_report_t expected_reports [$];
        int             faults;

        function new();
            foreach (screen[i])
            begin
                screen[i] = 8'h00;
                known[i]  = 1'b0;
            end
            col        = 0;
            row        = 0;
            fill_color = DEFAULT_COLOR_RESET;
            mono       = 1'b0;
            faults     = 0;
        endfunction

        function void set_config(logic [7:0] dflt, bit mono_sel);
            fill_color = dflt;
            mono       = mono_sel;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void shift_screen_up();
            int n;
            int c;
            if (mono)
            begin
                for (n = 0; n < (LINES - 1) * COLS; n++)
                begin
                    screen[n] = screen[n + COLS];
                    known[n]  = known[n + COLS];
                end
                for (n = 0; n < COLS; n++)
                begin
                    screen[(LINES - 1) * COLS + n] = CH_BLANK;
                    known[(LINES - 1) * COLS + n]  = 1'b1;
                end
            end
            else
            begin
                for (n = 0; n < (LINES - 1) * COLS * 2; n++)
                begin
                    screen[n] = screen[n + 2 * COLS];
                    known[n]  = known[n + 2 * COLS];
                end
                for (n = 0; n < COLS; n++)
                begin
                    c = (LINES - 1) * COLS + n;
                    screen[2 * c]     = CH_BLANK;
                    screen[2 * c + 1] = fill_color;
                    known[2 * c]      = 1'b1;
                    known[2 * c + 1]  = 1'b1;
                end
            end
            row = LINES - 1;
        endfunction

        function void line_feed();
            row++;
            if (row >= LINES)
                shift_screen_up();
        endfunction

        function void store_glyph(logic [7:0] ch, logic [7:0] attr);
            int slot;
            slot = row * COLS + col;
            if (mono)
            begin
                screen[slot] = ch;
                known[slot]  = 1'b1;
            end
            else
            begin
                screen[2 * slot]     = ch;
                screen[2 * slot + 1] = attr;
                known[2 * slot]      = 1'b1;
                known[2 * slot + 1]  = 1'b1;
            end
            col++;
            if (col >= COLS)
            begin
                col = 0;
                line_feed();
            end
        endfunction

        function void blank_screen();
            int i;
            col = 0;
            row = 0;
            for (i = 0; i < CELLS; i++)
            begin
                if (mono)
                begin
                    screen[i] = CH_BLANK;
                    known[i]  = 1'b1;
                end
                else
                begin
                    screen[2 * i]     = CH_BLANK;
                    screen[2 * i + 1] = fill_color;
                    known[2 * i]      = 1'b1;
                    known[2 * i + 1]  = 1'b1;
                end
            end
        endfunction

        // Never pick a byte that holds nothing defined yet.
        function logic [11:0] pick_read_address();
            logic [11:0] a;
            int          k;
            for (k = 0; k < 16; k++)
            begin
                a = 12'($urandom_range(4095));
                if (a >= STORE_BYTES || known[a])
                    return a;
            end
            return 12'(STORE_BYTES + $urandom_range(4095 - STORE_BYTES));
        endfunction

        function void note_command(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
                                   logic [11:0] addr);
            cursor_report_t rep;
            logic [7:0]     rd;
            rd = 8'h00;
            if (op == OP_PUT)
            begin
                if (ch == CH_LF)
                    line_feed();
                else if (ch == CH_CR)
                    col = 0;
                else if (ch == CH_TAB)
                    repeat (4) store_glyph(CH_BLANK, attr);
                else
                    store_glyph(ch, attr);
            end
            else if (op == OP_CLEAR)
                blank_screen();
            else if (op == OP_READ && addr < STORE_BYTES)
                rd = screen[addr];
            rep.col  = 7'(col);
            rep.row  = 5'(row);
            rep.pos  = 11'(row * COLS + col);
            rep.data = rd;
            expected_reports.push_back(rep);
        endfunction

        function void check_report(logic [6:0] c, logic [4:0] r, logic [10:0] pos,
                                   logic [7:0] d);
            cursor_report_t exp_rep;
            if (expected_reports.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("cursor report with nothing outstanding: col %0d row %0d pos %0d",
                             c, r, pos);
                return;
            end
            exp_rep = expected_reports.pop_front();
            if (c !== exp_rep.col || r !== exp_rep.row || pos !== exp_rep.pos
                || d !== exp_rep.data)
            begin
                faults++;
                if (faults <= 10)
                    $display({"cursor report mismatch: col %0d exp %0d, row %0d exp %0d, ",
                              "pos %0d exp %0d, data %02h exp %02h"},
                             c, exp_rep.col, r, exp_rep.row, pos, exp_rep.pos,
                             d, exp_rep.data);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [11:0] read_address;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_position;
    logic [7:0]  read_data;

    console_scoreboard sb;
    int items_sent;
    int items_noted;
    int in_idle_pct;
    int out_stall_pct;
    int quiet_cycles;

    text_console_writer_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .char_code       (char_code),
        .color           (color),
        .read_address    (read_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_position (cursor_position),
        .read_data       (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    // Check the result beat before noting the input beat of the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_report(cursor_col, cursor_row, cursor_position, read_data);
            if (in_valid && !in_stall)
            begin
                sb.note_command(opcode, char_code, color, read_address);
                items_noted = items_noted + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_text_console_writer_unit: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] attr,
                        input logic [11:0] addr);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        char_code    <= ch;
        color        <= attr;
        read_address <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        // Let the scoreboard take this beat before the next one is chosen.
        wait (items_noted == items_sent);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send(OP_PUT, ch, 8'($urandom), 12'($urandom));
    endtask

    task automatic read_byte();
        send(OP_READ, 8'($urandom), 8'($urandom), sb.pick_read_address());
    endtask

    task automatic clear_screen_cmd();
        send(OP_CLEAR, 8'($urandom), 8'($urandom), 12'($urandom));
    endtask

    // Hold the sender until every result beat is back and the engine has gone idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] dflt, input logic mono_sel);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEFAULT_COLOR;
        cfg_data  <= dflt;
        @(posedge clk);
        cfg_index <= REG_MONO_MODE;
        cfg_data  <= {7'd0, mono_sel};
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(dflt, mono_sel);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int n;
        int r;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(9))
                4:
                begin
                    // long tab run: can wrap past the last column
                    n = $urandom_range(24, 18);
                    repeat (n) put_char(CH_TAB);
                end
                5, 6:
                begin
                    n = $urandom_range(14, 2);
                    repeat (n) put_char(CH_LF);
                end
                7:
                begin
                    n = $urandom_range(8, 3);
                    repeat (n) read_byte();
                end
                8:
                begin
                    clear_screen_cmd();
                    drain();
                end
                9:
                begin
                    n = $urandom_range(30, 20);
                    repeat (n) put_char(8'($urandom_range(8'h7e, 8'h21)));
                    put_char(CH_CR);
                end
                default:
                begin
                    n = $urandom_range(16, 8);
                    repeat (n)
                    begin
                        r = $urandom_range(99);
                        if (r < 50)
                            put_char(8'($urandom));
                        else if (r < 58)
                            put_char(CH_LF);
                        else if (r < 63)
                            put_char(CH_CR);
                        else if (r < 70)
                            put_char(CH_TAB);
                        else if (r < 88)
                            read_byte();
                        else if (r < 92)
                            clear_screen_cmd();
                        else
                            send(OP_UNUSED, 8'($urandom), 8'($urandom), 12'($urandom));
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        int p;
        sb            = new();
        items_sent    = 0;
        items_noted   = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_DEFAULT_COLOR;
        cfg_data     <= 8'h00;
        in_valid     <= 1'b0;
        opcode       <= OP_PUT;
        char_code    <= 8'h00;
        color        <= 8'h00;
        read_address <= 12'h000;
        out_stall    <= 1'b0;
        quiet_cycles <= 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: write before any clear, then clear and probe the store edges.
        send(OP_PUT, 8'h41, 8'h00, 12'hFFF);
        send(OP_READ, 8'h00, 8'h00, 12'd0);
        send(OP_READ, 8'hFF, 8'hFF, 12'd1);
        send(OP_CLEAR, 8'h00, 8'h00, 12'h000);
        send(OP_READ, 8'h00, 8'h00, 12'(STORE_BYTES - 1));
        send(OP_READ, 8'h00, 8'h00, 12'(STORE_BYTES));
        send(OP_READ, 8'h00, 8'h00, 12'hFFF);
        send(OP_PUT, 8'hFF, 8'hFF, 12'h000);
        send(OP_PUT, 8'h00, 8'hA5, 12'hFFF);
        send(OP_PUT, CH_TAB, 8'h5A, 12'h000);
        send(OP_READ, 8'h00, 8'h00, 12'd5);
        send(OP_READ, 8'h00, 8'h00, 12'd2);
        send(OP_PUT, CH_CR, 8'h00, 12'h000);
        send(OP_PUT, CH_LF, 8'h00, 12'h000);
        send(OP_UNUSED, 8'hFF, 8'hFF, 12'hFFF);
        send(OP_READ, 8'h00, 8'h00, 12'd3);

        for (p = 0; p < 4; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    write_config(8'h00, 1'b0);
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
                1:
                begin
                    write_config(8'hFF, 1'b1);
                    in_idle_pct   = 73;
                    out_stall_pct = 0;
                end
                2:
                begin
                    write_config(8'($urandom), 1'b0);
                    in_idle_pct   = 0;
                    out_stall_pct = 73;
                end
                default:
                begin
                    write_config(8'($urandom), 1'b1);
                    in_idle_pct   = 17;
                    out_stall_pct = 17;
                end
            endcase
            run_random(75);
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.faults == 0 && sb.pending() == 0)
            $display("tb_text_console_writer_unit: done, clean");
        else
            $display("tb_text_console_writer_unit: done, errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_dp.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_unit.sv
test/tb_text_console_writer_unit.sv
